FILE: design/seg_pkg.sv
// ---------------------------------------------------------------------------
// seg_pkg
// Types and widths shared by the segment intersection pipeline.
// ---------------------------------------------------------------------------
package seg_pkg;

   localparam int CoordBits = 16;
   localparam int DiffBits  = CoordBits + 1;     // coordinate difference
   localparam int ProdBits  = 2 * DiffBits;      // product of two differences
   localparam int DetBits   = ProdBits + 1;      // determinant and numerators
   localparam int MagBits   = DetBits - 1;       // magnitude of determinant
   localparam int RemBits   = MagBits + 1;       // divider working remainder
   localparam int QuoBits   = CoordBits + 1;     // quotient and delta magnitude
   localparam int BaseBits  = CoordBits + 2;     // final coordinate arithmetic

   typedef struct packed {
      logic signed [CoordBits-1:0] a_start_x;
      logic signed [CoordBits-1:0] a_start_y;
      logic signed [CoordBits-1:0] a_end_x;
      logic signed [CoordBits-1:0] a_end_y;
      logic signed [CoordBits-1:0] b_start_x;
      logic signed [CoordBits-1:0] b_start_y;
      logic signed [CoordBits-1:0] b_end_x;
      logic signed [CoordBits-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                        hit;
      logic signed [CoordBits-1:0] cross_x;
      logic signed [CoordBits-1:0] cross_y;
   } rsp_type;

   // front end result handed to the divider
   typedef struct packed {
      logic                        hit;
      logic [MagBits-1:0]          den;
      logic [MagBits-1:0]          tnum;
      logic [QuoBits-1:0]          mag_x;
      logic                        neg_x;
      logic [QuoBits-1:0]          mag_y;
      logic                        neg_y;
      logic signed [CoordBits-1:0] x1;
      logic signed [CoordBits-1:0] y1;
   } frc_type;

endpackage

FILE: design/seg_front.sv
// ---------------------------------------------------------------------------
// seg_front
// Five stages: differences, products, determinants, sign fold, range check.
// ---------------------------------------------------------------------------
module seg_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_vld,
   input  seg_pkg::req_type in_data,
   output logic            out_vld,
   output seg_pkg::frc_type out_data
);
   import seg_pkg::*;

   typedef struct packed {
      logic signed [DiffBits-1:0]  dx12, dy34, dy12, dx34, dx13, dy13, dxa, dya;
      logic signed [CoordBits-1:0] x1, y1;
   } s1_type;

   typedef struct packed {
      logic signed [ProdBits-1:0]  p1, p2, p3, p4, p5, p6;
      logic signed [DiffBits-1:0]  dxa, dya;
      logic signed [CoordBits-1:0] x1, y1;
   } s2_type;

   typedef struct packed {
      logic signed [DetBits-1:0]   d, tn, un;
      logic signed [DiffBits-1:0]  dxa, dya;
      logic signed [CoordBits-1:0] x1, y1;
   } s3_type;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in, s4_ff, s4_in;
   frc_type s5_ff, s5_in;
   logic [4:0] vld_ff, vld_in;

   function automatic logic signed [DiffBits-1:0] dif(logic signed [CoordBits-1:0] a,
                                                      logic signed [CoordBits-1:0] b);
      return DiffBits'(a) - DiffBits'(b);
   endfunction

   always_comb begin
      s1_in.dx12 = dif(in_data.a_start_x, in_data.a_end_x);
      s1_in.dy34 = dif(in_data.b_start_y, in_data.b_end_y);
      s1_in.dy12 = dif(in_data.a_start_y, in_data.a_end_y);
      s1_in.dx34 = dif(in_data.b_start_x, in_data.b_end_x);
      s1_in.dx13 = dif(in_data.a_start_x, in_data.b_start_x);
      s1_in.dy13 = dif(in_data.a_start_y, in_data.b_start_y);
      s1_in.dxa  = dif(in_data.a_end_x, in_data.a_start_x);
      s1_in.dya  = dif(in_data.a_end_y, in_data.a_start_y);
      s1_in.x1   = in_data.a_start_x;
      s1_in.y1   = in_data.a_start_y;

      s2_in.p1  = ProdBits'(s1_ff.dx12) * ProdBits'(s1_ff.dy34);
      s2_in.p2  = ProdBits'(s1_ff.dy12) * ProdBits'(s1_ff.dx34);
      s2_in.p3  = ProdBits'(s1_ff.dx13) * ProdBits'(s1_ff.dy34);
      s2_in.p4  = ProdBits'(s1_ff.dy13) * ProdBits'(s1_ff.dx34);
      s2_in.p5  = ProdBits'(s1_ff.dy12) * ProdBits'(s1_ff.dx13);
      s2_in.p6  = ProdBits'(s1_ff.dx12) * ProdBits'(s1_ff.dy13);
      s2_in.dxa = s1_ff.dxa;
      s2_in.dya = s1_ff.dya;
      s2_in.x1  = s1_ff.x1;
      s2_in.y1  = s1_ff.y1;

      s3_in.d   = DetBits'(s2_ff.p1) - DetBits'(s2_ff.p2);
      s3_in.tn  = DetBits'(s2_ff.p3) - DetBits'(s2_ff.p4);
      s3_in.un  = DetBits'(s2_ff.p5) - DetBits'(s2_ff.p6);
      s3_in.dxa = s2_ff.dxa;
      s3_in.dya = s2_ff.dya;
      s3_in.x1  = s2_ff.x1;
      s3_in.y1  = s2_ff.y1;

      // fold the sign of d into all three
      s4_in = s3_ff;
      if (s3_ff.d[DetBits-1]) begin
         s4_in.d  = -s3_ff.d;
         s4_in.tn = -s3_ff.tn;
         s4_in.un = -s3_ff.un;
      end

      s5_in.hit   = (s4_ff.d != '0) && !s4_ff.tn[DetBits-1] && (s4_ff.tn <= s4_ff.d)
                    && !s4_ff.un[DetBits-1] && (s4_ff.un <= s4_ff.d);
      s5_in.den   = s4_ff.d[MagBits-1:0];
      s5_in.tnum  = s4_ff.tn[MagBits-1:0];
      s5_in.neg_x = s4_ff.dxa[DiffBits-1];
      s5_in.neg_y = s4_ff.dya[DiffBits-1];
      s5_in.mag_x = s4_ff.dxa[DiffBits-1] ? QuoBits'(-s4_ff.dxa) : QuoBits'(s4_ff.dxa);
      s5_in.mag_y = s4_ff.dya[DiffBits-1] ? QuoBits'(-s4_ff.dya) : QuoBits'(s4_ff.dya);
      s5_in.x1    = s4_ff.x1;
      s5_in.y1    = s4_ff.y1;

      vld_in = {vld_ff[3:0], in_vld};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_vld  = vld_ff[4];
   assign out_data = s5_ff;

endmodule

FILE: design/seg_div.sv
// ---------------------------------------------------------------------------
// seg_div
// Pipelined exact divide of tn * delta by d for both lanes, one quotient
// bit per stage, then truncation toward zero of the crossing point.
// ---------------------------------------------------------------------------
module seg_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  seg_pkg::frc_type in_data,
   output logic             out_vld,
   output seg_pkg::rsp_type out_data
);
   import seg_pkg::*;

   localparam int Steps = QuoBits;

   typedef struct packed {
      frc_type            f;
      logic [RemBits-1:0] rx, ry;
      logic [QuoBits-1:0] qx, qy;
   } dst_type;

   dst_type  st_ff [0:Steps];
   dst_type  st_in [0:Steps];
   logic [Steps:0] vld_ff;
   rsp_type  fin_ff, fin_in;
   logic     fin_vld_ff;

   function automatic logic signed [CoordBits-1:0] fix(logic signed [CoordBits-1:0] s0,
                                                       logic neg,
                                                       logic [QuoBits-1:0] q,
                                                       logic [RemBits-1:0] r);
      logic signed [BaseBits-1:0] base;
      if (neg) begin
         base = BaseBits'(s0) - BaseBits'(q) - BaseBits'(r != '0);
      end else begin
         base = BaseBits'(s0) + BaseBits'(q);
      end
      if (r != '0 && base[BaseBits-1]) begin
         base = base + BaseBits'(1);
      end
      return base[CoordBits-1:0];
   endfunction

   always_comb begin
      st_in[0].f  = in_data;
      st_in[0].rx = '0;
      st_in[0].ry = '0;
      st_in[0].qx = '0;
      st_in[0].qy = '0;
   end

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [RemBits-1:0] r2x, r2y, dd, d2;
      always_comb begin
         dd  = RemBits'(st_ff[k].f.den);
         d2  = {st_ff[k].f.den, 1'b0};
         r2x = {st_ff[k].rx[RemBits-2:0], 1'b0}
               + (st_ff[k].f.mag_x[Steps-1-k] ? RemBits'(st_ff[k].f.tnum) : '0);
         r2y = {st_ff[k].ry[RemBits-2:0], 1'b0}
               + (st_ff[k].f.mag_y[Steps-1-k] ? RemBits'(st_ff[k].f.tnum) : '0);
         st_in[k+1].f = st_ff[k].f;
         // partial remainder stays below 3d, so at most two subtracts
         if (r2x >= d2) begin
            st_in[k+1].rx = r2x - d2;
            st_in[k+1].qx = {st_ff[k].qx[QuoBits-2:0], 1'b0} + QuoBits'(2);
         end else if (r2x >= dd) begin
            st_in[k+1].rx = r2x - dd;
            st_in[k+1].qx = {st_ff[k].qx[QuoBits-2:0], 1'b1};
         end else begin
            st_in[k+1].rx = r2x;
            st_in[k+1].qx = {st_ff[k].qx[QuoBits-2:0], 1'b0};
         end
         if (r2y >= d2) begin
            st_in[k+1].ry = r2y - d2;
            st_in[k+1].qy = {st_ff[k].qy[QuoBits-2:0], 1'b0} + QuoBits'(2);
         end else if (r2y >= dd) begin
            st_in[k+1].ry = r2y - dd;
            st_in[k+1].qy = {st_ff[k].qy[QuoBits-2:0], 1'b1};
         end else begin
            st_in[k+1].ry = r2y;
            st_in[k+1].qy = {st_ff[k].qy[QuoBits-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      fin_in.hit     = st_ff[Steps].f.hit;
      fin_in.cross_x = '0;
      fin_in.cross_y = '0;
      if (st_ff[Steps].f.hit) begin
         fin_in.cross_x = fix(st_ff[Steps].f.x1, st_ff[Steps].f.neg_x,
                              st_ff[Steps].qx, st_ff[Steps].rx);
         fin_in.cross_y = fix(st_ff[Steps].f.y1, st_ff[Steps].f.neg_y,
                              st_ff[Steps].qy, st_ff[Steps].ry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fin_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[Steps-1:0], in_vld};
         fin_vld_ff <= vld_ff[Steps];
      end
      if (en) begin
         for (int i = 0; i <= Steps; i++) begin
            st_ff[i] <= st_in[i];
         end
         fin_ff <= fin_in;
      end
   end

   assign out_vld  = fin_vld_ff;
   assign out_data = fin_ff;

endmodule

FILE: design/seg_out.sv
// ---------------------------------------------------------------------------
// seg_out
// Output register with a skid entry; the pipeline advances while the skid
// entry is empty.
// ---------------------------------------------------------------------------
module seg_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  seg_pkg::rsp_type in_data,
   output logic             en,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output seg_pkg::rsp_type rsp_data
);
   import seg_pkg::*;

   logic    out_vld_ff, skid_vld_ff;
   rsp_type out_ff, skid_ff;

   assign en = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_ready) begin
            out_vld_ff  <= 1'b1;
            out_ff      <= skid_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || rsp_ready) begin
         out_vld_ff <= in_vld;
         out_ff     <= in_data;
      end else if (in_vld) begin
         // output stalled, park the arriving result
         skid_vld_ff <= 1'b1;
         skid_ff     <= in_data;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: design/segment_intersection.sv
// ---------------------------------------------------------------------------
// segment_intersection
// Path: front stages, divider stages, divider result register, output register, then rsp_valid.
// Throughput: one request per cycle while the skid entry is empty, with a one-bit-per-stage divider.
// Reset: synchronous, active high; clears all valid bits, pipeline empty.
// Exact integer test of two segments, crossing point truncated toward zero.
// ---------------------------------------------------------------------------
module segment_intersection (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  seg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output seg_pkg::rsp_type rsp_data
);
   import seg_pkg::*;

   logic    en;
   logic    frc_vld, div_vld;
   frc_type frc_data;
   rsp_type div_data;

   assign req_ready = en;

   seg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid & en),
      .in_data  (req_data),
      .out_vld  (frc_vld),
      .out_data (frc_data)
   );

   seg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (frc_vld),
      .in_data  (frc_data),
      .out_vld  (div_vld),
      .out_data (div_data)
   );

   seg_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (div_vld),
      .in_data   (div_data),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/segment_intersection_test.sv
// ---------------------------------------------------------------------------
// segment_intersection_test
// Self-checking bench for the segment intersection pipeline.
// Drives segment pairs with random gaps and back-pressure, predicts each
// crossing exactly in wide integers and compares every response in order.
// ---------------------------------------------------------------------------
module segment_intersection_test;
   import seg_pkg::*;

   // in-order store of predicted crossings
   class crossing_board;
      rsp_type pending[$];
      int      mismatches;
      int      checked;
      int      hits;

      function rsp_type predict(req_type r);
         rsp_type         p;
         longint          x1, y1, x2, y2, x3, y3, x4, y4;
         longint          det, tn, un, qx, qy;
         p  = '0;
         x1 = r.a_start_x; y1 = r.a_start_y; x2 = r.a_end_x; y2 = r.a_end_y;
         x3 = r.b_start_x; y3 = r.b_start_y; x4 = r.b_end_x; y4 = r.b_end_y;
         det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
         if (det == 0) return p;
         tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
         un = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
         if (det < 0) begin
            det = -det; tn = -tn; un = -un;
         end
         if (tn < 0 || tn > det || un < 0 || un > det) return p;
         qx = trunc_coord(x1, x2 - x1, tn, det);
         qy = trunc_coord(y1, y2 - y1, tn, det);
         p.hit = 1'b1;
         p.cross_x = qx[CoordBits-1:0];
         p.cross_y = qy[CoordBits-1:0];
         return p;
      endfunction

      // start + tn/det * delta, truncated toward zero; fits in 64 bits
      function longint trunc_coord(longint s0, longint delta, longint tn, longint det);
         longint num, q;
         num = s0 * det + tn * delta;
         q = num / det;
         return q;
      endfunction

      function void note_request(req_type r);
         rsp_type p;
         p = predict(r);
         if (p.hit) hits++;
         pending.push_back(p);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report_miss("unexpected response", '0, got);
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit || got.cross_x !== want.cross_x
             || got.cross_y !== want.cross_y)
            report_miss("wrong response", want, got);
      endfunction

      function void report_miss(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     what, want.hit, want.cross_x, want.cross_y,
                     got.hit, got.cross_x, got.cross_y);
      endfunction
   endclass

   localparam int RandomPairs = 900;
   localparam int Latency     = 25;
   localparam int IdleLimit   = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   crossing_board board = new();
   bit  sending_done = 1'b0;
   bit  hold_rsp = 1'b0;
   int  sent = 0;
   int  idle_cycles = 0;

   segment_intersection dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [CoordBits-1:0] rand_coord(bit tiny);
      int sel;
      sel = $urandom_range(0, 9);
      if (tiny) return CoordBits'(int'($urandom_range(0, 40)) - 20);
      if (sel == 0) return {1'b1, {(CoordBits-1){1'b0}}};
      if (sel == 1) return {1'b0, {(CoordBits-1){1'b1}}};
      return CoordBits'($urandom);
   endfunction

   // valid stays high into the next request when there is no gap
   task automatic send_pair(req_type r);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
      sent++;
   endtask

   // random pair, mostly with small extent; sometimes b starts at the end of a
   function automatic req_type crossing_pair();
      req_type r;
      bit      tiny;
      tiny = $urandom_range(0, 3) != 0;
      r.a_start_x = rand_coord(tiny); r.a_start_y = rand_coord(tiny);
      r.a_end_x   = rand_coord(tiny); r.a_end_y   = rand_coord(tiny);
      r.b_start_x = rand_coord(tiny); r.b_start_y = rand_coord(tiny);
      r.b_end_x   = rand_coord(tiny); r.b_end_y   = rand_coord(tiny);
      if ($urandom_range(0, 4) == 0) begin
         // share an endpoint to hit the closed-range boundary
         r.b_start_x = r.a_end_x; r.b_start_y = r.a_end_y;
      end
      return r;
   endfunction

   task automatic directed_pairs();
      req_type r;
      logic signed [CoordBits-1:0] lo, hi;
      lo = {1'b1, {(CoordBits-1){1'b0}}};
      hi = {1'b0, {(CoordBits-1){1'b1}}};
      // plain cross, T junction, shared endpoint, miss
      send_pair('{0, 0, 10, 10, 0, 10, 10, 0});
      send_pair('{0, 0, 10, 0, 5, 0, 5, 7});
      send_pair('{0, 0, 4, 4, 4, 4, 9, -3});
      send_pair('{0, 0, 1, 1, 5, 0, 6, -1});
      // parallel, collinear, point segment
      send_pair('{0, 0, 10, 0, 0, 3, 10, 3});
      send_pair('{0, 0, 10, 0, 2, 0, 7, 0});
      send_pair('{3, 3, 3, 3, 0, 0, 9, 9});
      // fractional crossings with negative results
      send_pair('{-7, -1, 0, 2, -5, 3, -4, -6});
      send_pair('{0, 0, -3, -2, -2, 0, 0, -3});
      // full-range extremes
      send_pair('{lo, lo, hi, hi, lo, hi, hi, lo});
      send_pair('{hi, lo, lo, hi, lo, lo, hi, hi});
      send_pair('{lo, lo, lo, hi, lo, lo, hi, lo});
      send_pair('{hi, hi, lo, lo, hi, lo, lo, hi});
      send_pair('{lo, 0, hi, 1, 0, lo, 1, hi});
      r = '1; send_pair(r);
      r = '0; send_pair(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_pairs();
      wait_drained();
      for (int i = 0; i < RandomPairs; i++) begin
         if (i == 300) begin
            wait_drained();
            hold_rsp = 1'b1;
         end
         send_pair(crossing_pair());
      end
      wait_drained();
      repeat (Latency + 5) @(posedge clock);
      sending_done = 1'b1;
   end

   // response side: random stalls and one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (sending_done || idle_cycles >= IdleLimit);
      if (!sending_done) begin
         $display("timeout with %0d responses outstanding", board.pending.size());
         $display("*** FAILED ***");
      end else begin
         $display("%0d segment pairs sent, %0d responses checked, %0d crossings",
                  sent, board.checked, board.hits);
         if (board.mismatches == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
         else
            $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: segment_intersection.f
design/seg_pkg.sv
design/seg_front.sv
design/seg_div.sv
design/seg_out.sv
design/segment_intersection.sv
verif/segment_intersection_test.sv
